// File: hw/rtl/hclb_pkg.sv
// ----------------------------------------------------------------------------
// hclb_pkg
// Shared constants and codes for the Huffman code length builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package hclb_pkg;

  localparam int NUM_SYMBOLS = 257;
  localparam int COUNT_WIDTH = 32;
  localparam int END_SYM     = NUM_SYMBOLS - 1;
  localparam int NUM_NODES   = 2 * NUM_SYMBOLS - 1;
  localparam int NUM_MERGED  = NUM_SYMBOLS - 1;

  localparam int SYM_W    = $clog2(NUM_SYMBOLS);
  localparam int IDX_W    = $clog2(NUM_SYMBOLS + 1);
  localparam int NODE_W   = $clog2(NUM_NODES);
  localparam int DADDR_W  = $clog2(NUM_MERGED);
  localparam int LEN_W    = 9;
  localparam int TOTAL_W  = 40;
  localparam int WEIGHT_W = COUNT_WIDTH + $clog2(NUM_SYMBOLS);
  localparam int QENT_W   = WEIGHT_W + NODE_W;
  localparam int CL_W     = LEN_W + 1;

  typedef enum logic [1:0] {
    FUNC_COUNT = 2'd0,
    FUNC_BUILD = 2'd1,
    FUNC_READ  = 2'd2,
    FUNC_CLEAR = 2'd3
  } func_e;

endpackage

// File: hw/rtl/huffman_code_length_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_length_builder
// Byte counter and Huffman code length builder over on-chip memories.
// ----------------------------------------------------------------------------
// One item is taken at a time. Counting a byte reads and writes back the
// count memory. A read waits, if need be, for the result slot. Clearing the
// counts sweeps the count memory; the same sweep runs after reset and also
// clears the code lengths. A build first loads the leaves. Each merge then
// scans the node queue twice, follows each scan with a removal step and
// pushes the merged node. Finally it walks every node once from the root
// down.
`timescale 1ns / 1ps

module huffman_code_length_builder (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [1:0]                          func_i,
  input  logic [8:0]                          symbol_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [8:0]                          symbol_out_o,
  output logic                                present_o,
  output logic [hclb_pkg::COUNT_WIDTH-1:0]    occurrences_o,
  output logic [8:0]                          code_length_o,
  output logic [hclb_pkg::TOTAL_W-1:0]        total_bits_o
);

  import hclb_pkg::*;

  typedef enum logic [11:0] {
    S_IDLE    = 12'b0000_0000_0001,
    S_CLEAR   = 12'b0000_0000_0010,
    S_CNT_WR  = 12'b0000_0000_0100,
    S_INIT    = 12'b0000_0000_1000,
    S_SCAN    = 12'b0000_0001_0000,
    S_PICK    = 12'b0000_0010_0000,
    S_MERGE   = 12'b0000_0100_0000,
    S_WALK_A  = 12'b0000_1000_0000,
    S_WALK_B  = 12'b0001_0000_0000,
    S_WALK_C  = 12'b0010_0000_0000,
    S_RD_DATA = 12'b0100_0000_0000,
    S_RD_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  logic [IDX_W-1:0]       idx_q, idx_d;
  logic                   clr_cl_q, clr_cl_d;
  logic [IDX_W-1:0]       qsize_q, qsize_d;
  logic [NODE_W-1:0]      next_q, next_d;
  logic                   rv_q, rv_d;
  logic [IDX_W-1:0]       pos_q, pos_d;
  logic [WEIGHT_W-1:0]    best_w_q, best_w_d;
  logic [NODE_W-1:0]      best_n_q, best_n_d;
  logic [IDX_W-1:0]       best_p_q, best_p_d;
  logic [QENT_W-1:0]      last_q, last_d;
  logic                   take_q, take_d;
  logic [WEIGHT_W-1:0]    first_w_q, first_w_d;
  logic [NODE_W-1:0]      node_q, node_d;
  logic [SYM_W-1:0]       sym_q, sym_d;
  logic                   oob_q, oob_d;

  // read result staging
  logic [TOTAL_W-1:0]     prod_q, prod_d;
  logic [COUNT_WIDTH-1:0] occ_q, occ_d;
  logic                   pres_q, pres_d;
  logic [LEN_W-1:0]       len_q, len_d;

  logic                   out_valid_q, out_valid_d;
  logic [SYM_W-1:0]       out_sym_q, out_sym_d;
  logic                   out_pres_q, out_pres_d;
  logic [COUNT_WIDTH-1:0] out_occ_q, out_occ_d;
  logic [LEN_W-1:0]       out_len_q, out_len_d;
  logic [TOTAL_W-1:0]     out_tot_q, out_tot_d;

  // memory ports
  logic                   cnt_we;
  logic [SYM_W-1:0]       cnt_waddr, cnt_raddr;
  logic [COUNT_WIDTH-1:0] cnt_wdata, cnt_rdata;
  logic                   cl_we;
  logic [SYM_W-1:0]       cl_waddr, cl_raddr;
  logic [CL_W-1:0]        cl_wdata, cl_rdata;
  logic                   q_we;
  logic [SYM_W-1:0]       q_waddr, q_raddr;
  logic [QENT_W-1:0]      q_wdata, q_rdata;
  logic                   par_we;
  logic [NODE_W-1:0]      par_waddr, par_raddr;
  logic [NODE_W-1:0]      par_wdata, par_rdata;
  logic                   dep_we;
  logic [DADDR_W-1:0]     dep_waddr, dep_raddr;
  logic [LEN_W-1:0]       dep_wdata, dep_rdata;

  // scratch
  logic                   accept;
  logic                   use_leaf;
  logic                   better;
  logic [WEIGHT_W-1:0]    e_w;
  logic [NODE_W-1:0]      e_n;
  logic                   is_leaf;
  logic [COUNT_WIDTH+LEN_W-1:0] prod_full;
  logic [NODE_W-1:0]      par_off;

  hclb_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(NUM_SYMBOLS)) u_cnt_ram (
    .clk_i, .we_i(cnt_we), .waddr_i(cnt_waddr), .wdata_i(cnt_wdata),
    .raddr_i(cnt_raddr), .rdata_o(cnt_rdata)
  );

  hclb_ram #(.WIDTH(CL_W), .DEPTH(NUM_SYMBOLS)) u_cl_ram (
    .clk_i, .we_i(cl_we), .waddr_i(cl_waddr), .wdata_i(cl_wdata),
    .raddr_i(cl_raddr), .rdata_o(cl_rdata)
  );

  hclb_ram #(.WIDTH(QENT_W), .DEPTH(NUM_SYMBOLS)) u_queue_ram (
    .clk_i, .we_i(q_we), .waddr_i(q_waddr), .wdata_i(q_wdata),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  hclb_ram #(.WIDTH(NODE_W), .DEPTH(NUM_NODES)) u_parent_ram (
    .clk_i, .we_i(par_we), .waddr_i(par_waddr), .wdata_i(par_wdata),
    .raddr_i(par_raddr), .rdata_o(par_rdata)
  );

  hclb_ram #(.WIDTH(LEN_W), .DEPTH(NUM_MERGED)) u_depth_ram (
    .clk_i, .we_i(dep_we), .waddr_i(dep_waddr), .wdata_i(dep_wdata),
    .raddr_i(dep_raddr), .rdata_o(dep_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  assign e_w       = q_rdata[QENT_W-1:NODE_W];
  assign e_n       = q_rdata[NODE_W-1:0];
  assign is_leaf   = (node_q < NODE_W'(NUM_SYMBOLS));
  assign par_off   = par_rdata - NODE_W'(NUM_SYMBOLS);
  assign prod_full = (COUNT_WIDTH+LEN_W)'(cnt_rdata) * (COUNT_WIDTH+LEN_W)'(cl_rdata[LEN_W-1:0]);

  // control and datapath sequencing
  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    clr_cl_d    = clr_cl_q;
    qsize_d     = qsize_q;
    next_d      = next_q;
    rv_d        = 1'b0;
    pos_d       = pos_q;
    best_w_d    = best_w_q;
    best_n_d    = best_n_q;
    best_p_d    = best_p_q;
    last_d      = last_q;
    take_d      = take_q;
    first_w_d   = first_w_q;
    node_d      = node_q;
    sym_d       = sym_q;
    oob_d       = oob_q;
    prod_d      = prod_q;
    occ_d       = occ_q;
    pres_d      = pres_q;
    len_d       = len_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_sym_d   = out_sym_q;
    out_pres_d  = out_pres_q;
    out_occ_d   = out_occ_q;
    out_len_d   = out_len_q;
    out_tot_d   = out_tot_q;

    cnt_we    = 1'b0;
    cnt_waddr = idx_q[SYM_W-1:0];
    cnt_wdata = '0;
    cnt_raddr = symbol_i[SYM_W-1:0];
    cl_we     = 1'b0;
    cl_waddr  = idx_q[SYM_W-1:0];
    cl_wdata  = '0;
    cl_raddr  = symbol_i[SYM_W-1:0];
    q_we      = 1'b0;
    q_waddr   = qsize_q[SYM_W-1:0];
    q_wdata   = '0;
    q_raddr   = idx_q[SYM_W-1:0];
    par_we    = 1'b0;
    par_waddr = best_n_q;
    par_wdata = next_q;
    par_raddr = node_q;
    dep_we    = 1'b0;
    dep_waddr = DADDR_W'(node_q - NODE_W'(NUM_SYMBOLS));
    dep_wdata = '0;
    dep_raddr = par_off[DADDR_W-1:0];
    use_leaf  = 1'b0;
    better    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          sym_d = symbol_i[SYM_W-1:0];
          unique case (func_e'(func_i))
            FUNC_COUNT: state_d = S_CNT_WR;
            FUNC_BUILD: begin
              idx_d   = '0;
              qsize_d = '0;
              next_d  = NODE_W'(NUM_SYMBOLS);
              state_d = S_INIT;
            end
            FUNC_READ: begin
              oob_d   = (symbol_i >= 9'(NUM_SYMBOLS));
              state_d = S_RD_DATA;
            end
            FUNC_CLEAR: begin
              idx_d   = '0;
              state_d = S_CLEAR;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end

      // sweep counts to zero; after reset also the code lengths
      S_CLEAR: begin
        cnt_we = 1'b1;
        cl_we  = clr_cl_q;
        if (idx_q == IDX_W'(NUM_SYMBOLS - 1)) begin
          clr_cl_d = 1'b0;
          state_d  = S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end

      // saturating increment, end marker and beyond are ignored
      S_CNT_WR: begin
        cnt_waddr = sym_q;
        cnt_wdata = cnt_rdata + 1'b1;
        cnt_we    = (sym_q < SYM_W'(END_SYM)) && !(&cnt_rdata);
        state_d   = S_IDLE;
      end

      // read counts, mark leaves present, load queue
      S_INIT: begin
        cnt_raddr = idx_q[SYM_W-1:0];
        if (idx_q < IDX_W'(NUM_SYMBOLS)) begin
          rv_d  = 1'b1;
          pos_d = idx_q;
          idx_d = idx_q + 1'b1;
        end
        if (rv_q) begin
          use_leaf = (pos_q == IDX_W'(END_SYM)) || (cnt_rdata != '0);
          cl_we    = 1'b1;
          cl_waddr = pos_q[SYM_W-1:0];
          cl_wdata = {use_leaf, {LEN_W{1'b0}}};
          if (use_leaf) begin
            q_we    = 1'b1;
            q_wdata = {(pos_q == IDX_W'(END_SYM)) ? {WEIGHT_W{1'b0}}
                                                   : WEIGHT_W'(cnt_rdata),
                       NODE_W'(pos_q)};
            qsize_d = qsize_q + 1'b1;
          end
          if (pos_q == IDX_W'(END_SYM)) begin
            rv_d = 1'b0;
            idx_d = '0;
            take_d = 1'b0;
            if (qsize_q != '0) begin
              state_d = S_SCAN;
            end else begin
              node_d  = NODE_W'(END_SYM);
              state_d = S_WALK_A;
            end
          end
        end
      end

      // scan queue for lightest node, lower index on a tie
      S_SCAN: begin
        if (idx_q < qsize_q) begin
          rv_d  = 1'b1;
          pos_d = idx_q;
          idx_d = idx_q + 1'b1;
        end
        if (rv_q) begin
          better = (pos_q == '0) || (e_w < best_w_q) ||
                   ((e_w == best_w_q) && (e_n < best_n_q));
          if (better) begin
            best_w_d = e_w;
            best_n_d = e_n;
            best_p_d = pos_q;
          end
          if (pos_q == qsize_q - 1'b1) begin
            last_d  = q_rdata;
            rv_d    = 1'b0;
            state_d = S_PICK;
          end
        end
      end

      // remove picked node: move last entry into its slot, record its parent
      S_PICK: begin
        q_we      = 1'b1;
        q_waddr   = best_p_q[SYM_W-1:0];
        q_wdata   = last_q;
        qsize_d   = qsize_q - 1'b1;
        par_we    = 1'b1;
        if (!take_q) begin
          first_w_d = best_w_q;
          take_d    = 1'b1;
          idx_d     = '0;
          state_d   = S_SCAN;
        end else begin
          take_d  = 1'b0;
          state_d = S_MERGE;
        end
      end

      // push merged node
      S_MERGE: begin
        q_we    = 1'b1;
        q_wdata = {first_w_q + best_w_q, next_q};
        qsize_d = qsize_q + 1'b1;
        next_d  = next_q + 1'b1;
        idx_d   = '0;
        if (qsize_q != '0) begin
          state_d = S_SCAN;
        end else begin
          node_d  = next_q;
          state_d = S_WALK_A;
        end
      end

      // top-down walk: root gets depth 0, others parent depth plus one
      S_WALK_A: begin
        cl_raddr = node_q[SYM_W-1:0];
        if (node_q == next_q - 1'b1) begin
          dep_we = !is_leaf;
          if (node_q == '0) begin
            state_d = S_IDLE;
          end else begin
            node_d = node_q - 1'b1;
          end
        end else begin
          state_d = S_WALK_B;
        end
      end

      S_WALK_B: begin
        if (is_leaf && !cl_rdata[LEN_W]) begin
          if (node_q == '0) begin
            state_d = S_IDLE;
          end else begin
            node_d  = node_q - 1'b1;
            state_d = S_WALK_A;
          end
        end else begin
          state_d = S_WALK_C;
        end
      end

      S_WALK_C: begin
        dep_wdata = dep_rdata + 1'b1;
        dep_we    = !is_leaf;
        cl_we     = is_leaf;
        cl_waddr  = node_q[SYM_W-1:0];
        cl_wdata  = {1'b1, dep_rdata + 1'b1};
        if (node_q == '0) begin
          state_d = S_IDLE;
        end else begin
          node_d  = node_q - 1'b1;
          state_d = S_WALK_A;
        end
      end

      // read entry: count times length, saturated; all zero when out of range
      S_RD_DATA: begin
        occ_d  = oob_q ? '0 : cnt_rdata;
        pres_d = oob_q ? 1'b0 : cl_rdata[LEN_W];
        len_d  = oob_q ? '0 : cl_rdata[LEN_W-1:0];
        if (oob_q) begin
          prod_d = '0;
        end else if (|prod_full[COUNT_WIDTH+LEN_W-1:TOTAL_W]) begin
          prod_d = '1;
        end else begin
          prod_d = prod_full[TOTAL_W-1:0];
        end
        state_d = S_RD_OUT;
      end

      S_RD_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_sym_d   = sym_q;
          out_pres_d  = pres_q;
          out_occ_d   = occ_q;
          out_len_d   = len_q;
          out_tot_d   = prod_q;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      idx_q       <= '0;
      clr_cl_q    <= 1'b1;
      qsize_q     <= '0;
      next_q      <= NODE_W'(NUM_SYMBOLS);
      rv_q        <= 1'b0;
      take_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      clr_cl_q    <= clr_cl_d;
      qsize_q     <= qsize_d;
      next_q      <= next_d;
      rv_q        <= rv_d;
      take_q      <= take_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pos_q      <= pos_d;
    best_w_q   <= best_w_d;
    best_n_q   <= best_n_d;
    best_p_q   <= best_p_d;
    last_q     <= last_d;
    first_w_q  <= first_w_d;
    node_q     <= node_d;
    sym_q      <= sym_d;
    oob_q      <= oob_d;
    prod_q     <= prod_d;
    occ_q      <= occ_d;
    pres_q     <= pres_d;
    len_q      <= len_d;
    out_sym_q  <= out_sym_d;
    out_pres_q <= out_pres_d;
    out_occ_q  <= out_occ_d;
    out_len_q  <= out_len_d;
    out_tot_q  <= out_tot_d;
  end

  assign out_valid_o   = out_valid_q;
  assign symbol_out_o  = 9'(out_sym_q);
  assign present_o     = out_pres_q;
  assign occurrences_o = out_occ_q;
  assign code_length_o = out_len_q;
  assign total_bits_o  = out_tot_q;

endmodule

// File: hw/rtl/hclb_ram.sv
// ----------------------------------------------------------------------------
// hclb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hclb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: bench/hclb_checker.sv
// ----------------------------------------------------------------------------
// hclb_checker
// Watches both channels of the code length builder, keeps its own copy of
// the byte counts and of the last built tree, and checks every read result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module hclb_checker (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  input  logic                             in_ready_i,
  input  logic [1:0]                       func_i,
  input  logic [8:0]                       symbol_i,
  input  logic                             out_valid_i,
  input  logic                             out_ready_i,
  input  logic [8:0]                       symbol_out_i,
  input  logic                             present_i,
  input  logic [hclb_pkg::COUNT_WIDTH-1:0] occurrences_i,
  input  logic [8:0]                       code_length_i,
  input  logic [hclb_pkg::TOTAL_W-1:0]     total_bits_i,
  output int                               fail_count_o,
  output int                               pending_o
);

  import hclb_pkg::*;

  typedef struct packed {
    logic [8:0]             sym;
    logic                   present;
    logic [COUNT_WIDTH-1:0] occ;
    logic [8:0]             len;
    logic [TOTAL_W-1:0]     total;
  } entry_t;

  localparam logic [COUNT_WIDTH-1:0] CNT_ALL_ONES = '1;
  localparam logic [47:0] TOTAL_ALL_ONES = (48'd1 << TOTAL_W) - 48'd1;

  // Model of the block state
  logic [COUNT_WIDTH-1:0] byte_count [NUM_SYMBOLS];
  logic [8:0]             leaf_depth [NUM_SYMBOLS];
  bit                     has_leaf   [NUM_SYMBOLS];

  // Scratch for the tree build
  logic [40:0] node_wgt    [NUM_NODES];
  int          node_par    [NUM_NODES];
  bit          node_linked [NUM_NODES];
  int          open_nodes  [NUM_SYMBOLS];
  int          open_cnt;

  entry_t expected_reads[$];
  int     mismatches;

  assign fail_count_o = mismatches;

  // Remove the lightest open node, lower index on a tie
  function automatic int pop_lightest();
    int best;
    int a;
    int b;
    int node;
    best = 0;
    for (int k = 1; k < open_cnt; k++) begin
      a = open_nodes[k];
      b = open_nodes[best];
      if (node_wgt[a] < node_wgt[b] || (node_wgt[a] == node_wgt[b] && a < b))
        best = k;
    end
    node = open_nodes[best];
    open_cnt--;
    open_nodes[best] = open_nodes[open_cnt];
    return node;
  endfunction

  function automatic void build_code_lengths();
    int next;
    int first;
    int second;
    int node;
    int depth;
    next = NUM_SYMBOLS;
    open_cnt = 0;
    for (int i = 0; i < NUM_NODES; i++) begin
      node_wgt[i]    = '0;
      node_par[i]    = 0;
      node_linked[i] = 0;
    end
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      has_leaf[i]   = (i == END_SYM) || (byte_count[i] != '0);
      leaf_depth[i] = '0;
      if (has_leaf[i]) begin
        node_wgt[i] = (i == END_SYM) ? '0 : 41'(byte_count[i]);
        open_nodes[open_cnt++] = i;
      end
    end
    while (open_cnt > 1 && next < NUM_NODES) begin
      first  = pop_lightest();
      second = pop_lightest();
      node_wgt[next]      = node_wgt[first] + node_wgt[second];
      node_par[first]     = next;
      node_linked[first]  = 1;
      node_par[second]    = next;
      node_linked[second] = 1;
      open_nodes[open_cnt++] = next;
      next++;
    end
    // Code length is the number of hops from leaf to root
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      if (has_leaf[i]) begin
        node  = i;
        depth = 0;
        while (node_linked[node] && depth < NUM_NODES) begin
          node = node_par[node];
          depth++;
        end
        leaf_depth[i] = 9'(depth);
      end
    end
  endfunction

  function automatic entry_t predict_read(logic [8:0] sym);
    entry_t e;
    logic [47:0] prod;
    e = '0;
    e.sym = sym;
    if (sym < NUM_SYMBOLS) begin
      e.occ = byte_count[sym];
      if (has_leaf[sym]) begin
        e.present = 1'b1;
        e.len     = leaf_depth[sym];
        prod      = 48'(byte_count[sym]) * 48'(leaf_depth[sym]);
        e.total   = (prod > TOTAL_ALL_ONES) ? '1 : prod[TOTAL_W-1:0];
      end
    end
    return e;
  endfunction

  initial begin
    mismatches = 0;
    for (int i = 0; i < NUM_SYMBOLS; i++) begin
      byte_count[i] = '0;
      leaf_depth[i] = '0;
      has_leaf[i]   = 0;
    end
  end

  // Outputs are checked before the input item of the same edge is modeled
  always @(posedge clk_i) begin
    entry_t exp_e;
    entry_t got;
    if (rst_ni) begin
      if (out_valid_i && out_ready_i) begin
        got = '{symbol_out_i, present_i, occurrences_i, code_length_i, total_bits_i};
        if (expected_reads.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result item, sym %0d", $realtime, symbol_out_i);
        end else begin
          exp_e = expected_reads.pop_front();
          if (got !== exp_e) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("%0t: read mismatch exp sym %0d pres %0d occ %0d len %0d tot %0d",
                       $realtime, exp_e.sym, exp_e.present, exp_e.occ, exp_e.len,
                       exp_e.total);
              $display("%0t:               got sym %0d pres %0d occ %0d len %0d tot %0d",
                       $realtime, got.sym, got.present, got.occ, got.len, got.total);
            end
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (func_e'(func_i))
          FUNC_COUNT: begin
            if (symbol_i < END_SYM && byte_count[symbol_i] != CNT_ALL_ONES)
              byte_count[symbol_i] = byte_count[symbol_i] + 1'b1;
          end
          FUNC_BUILD: build_code_lengths();
          FUNC_READ:  expected_reads.push_back(predict_read(symbol_i));
          FUNC_CLEAR: begin
            for (int i = 0; i < NUM_SYMBOLS; i++) byte_count[i] = '0;
          end
        endcase
      end
    end
    pending_o = expected_reads.size();
  end

endmodule

// File: bench/tb_huffman_code_length_builder.sv
// ----------------------------------------------------------------------------
// tb_huffman_code_length_builder
// Drives count, build, read and clear items into the code length builder
// under varying back-pressure; a checker alongside predicts every read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_huffman_code_length_builder;
  import hclb_pkg::*;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  logic [1:0]             func_i;
  logic [8:0]             symbol_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  logic [8:0]             symbol_out_o;
  logic                   present_o;
  logic [COUNT_WIDTH-1:0] occurrences_o;
  logic [8:0]             code_length_o;
  logic [TOTAL_W-1:0]     total_bits_o;

  int fail_count;
  int pending;
  int items_sent;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_req;
  bit hold_active;
  bit full_done;

  huffman_code_length_builder dut (.*);

  hclb_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i, .in_ready_i(in_ready_o), .func_i, .symbol_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .symbol_out_i(symbol_out_o), .present_i(present_o),
    .occurrences_i(occurrences_o), .code_length_i(code_length_o),
    .total_bits_i(total_bits_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Clock, 4 ns period
  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Run limit
  initial begin
    #20ms;
    $display("Some tests failed");
    $finish;
  end

  // Receiver, random stalls plus one long hold-off
  always @(posedge clk_i) begin
    out_ready_i <= hold_active ? 1'b0 : ($urandom_range(99) >= recv_idle_pct);
  end

  initial begin
    hold_active = 0;
    wait (hold_req);
    hold_active = 1;
    repeat (400) @(posedge clk_i);
    hold_active = 0;
  end

  // Offer one item and wait for its acceptance
  task automatic send(func_e f, logic [8:0] s);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      func_i     <= func_e'($urandom_range(3));
      symbol_i   <= 9'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i     <= f;
    symbol_i   <= s;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    if (items_sent == 550) begin
      send_idle_pct = 86;
      recv_idle_pct = 12;
    end else if (items_sent == 1100) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
      hold_req      = 1;
    end
  endtask

  // One well-formed pass: optional clear, count over a small alphabet, build, read
  task automatic run_frame(int alpha_n, bit clear_first);
    logic [8:0] alpha[$];
    int n;
    if (clear_first) send(FUNC_CLEAR, 9'($urandom));
    for (int i = 0; i < alpha_n; i++) alpha.push_back(9'($urandom_range(255)));
    n = $urandom_range(2, 40);
    for (int i = 0; i < n; i++) send(FUNC_COUNT, alpha[$urandom_range(alpha_n - 1)]);
    send(FUNC_BUILD, 9'($urandom));
    if ($urandom_range(3) == 0) send(FUNC_COUNT, alpha[0]);
    n = $urandom_range(3, 10);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) send(FUNC_READ, 9'($urandom));
      else send(FUNC_READ, alpha[$urandom_range(alpha_n - 1)]);
    end
  endtask

  initial begin
    items_sent    = 0;
    send_idle_pct = 12;
    recv_idle_pct = 86;
    hold_req      = 0;
    full_done     = 0;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    func_i        = FUNC_COUNT;
    symbol_i      = '0;
    out_ready_i   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: lone end marker, ignored counts, reads out of range
    send(FUNC_READ, 9'd0);
    send(FUNC_BUILD, 9'd0);
    send(FUNC_READ, 9'd256);
    send(FUNC_COUNT, 9'd256);
    send(FUNC_COUNT, 9'd511);
    send(FUNC_READ, 9'd511);
    send(FUNC_READ, 9'd257);
    send(FUNC_COUNT, 9'd0);
    send(FUNC_COUNT, 9'd255);
    send(FUNC_COUNT, 9'd255);
    send(FUNC_COUNT, 9'd170);
    send(FUNC_COUNT, 9'd85);
    send(FUNC_BUILD, 9'h1ff);
    send(FUNC_READ, 9'd255);
    send(FUNC_READ, 9'd0);
    send(FUNC_READ, 9'd256);
    send(FUNC_READ, 9'd1);
    // count changed after build, no leaf yet
    send(FUNC_COUNT, 9'd1);
    send(FUNC_READ, 9'd1);
    send(FUNC_COUNT, 9'd255);
    send(FUNC_READ, 9'd255);
    send(FUNC_CLEAR, 9'd0);
    send(FUNC_READ, 9'd255);
    send(FUNC_BUILD, 9'd0);
    send(FUNC_READ, 9'd85);

    // Random: mostly well-formed frames, some noise, one full alphabet
    while (items_sent < 1650) begin
      if (!full_done && items_sent > 800) begin
        full_done = 1;
        send(FUNC_CLEAR, 9'd0);
        for (int s = 0; s < 256; s++) send(FUNC_COUNT, 9'(s));
        for (int s = 0; s < 40; s++) send(FUNC_COUNT, 9'($urandom_range(255)));
        send(FUNC_BUILD, 9'd0);
        for (int s = 0; s < 6; s++) send(FUNC_READ, 9'($urandom_range(256)));
      end else if ($urandom_range(99) < 85) begin
        run_frame($urandom_range(1, 12), $urandom_range(4) != 0);
      end else begin
        repeat ($urandom_range(1, 8)) begin
          // noise, builds kept rare so accumulated alphabets stay small
          case ($urandom_range(9))
            0:       send(FUNC_BUILD, 9'($urandom));
            1:       send(FUNC_CLEAR, 9'($urandom));
            2, 3, 4: send(FUNC_READ, 9'($urandom));
            default: send(FUNC_COUNT, 9'($urandom));
          endcase
        end
      end
    end
    send(FUNC_READ, 9'($urandom_range(256)));
    in_valid_i <= 1'b0;

    wait (pending == 0);
    repeat (200) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
